// ===== sv/mlsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mergeable linked stack pool package
// Operation and status codes, sequencer states and fixed port widths.
// ----------------------------------------------------------------------------
package mlsp_pkg;

	localparam int OP_W     = 2;
	localparam int ID_W     = 2;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_MERGE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_UNDERFLOW  = 2'd1,
		ST_POOL_FULL  = 2'd2,
		ST_SELF_MERGE = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

endpackage

// ===== sv/mlsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module mlsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/mergeable_linked_stack_pool_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mergeable linked stack pool
// Several stacks share one pool of linked nodes; push, pop and merge words
// each return one result word carrying a popped value and a status code.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on in_valid/in_ready with operation, stack_id,
// other_stack_id and push_value. Each input word yields exactly one result
// word on out_valid/out_ready with pop_value and status.
// An accepted word reads the node memories in the idle state and updates
// the stack pointers, the free list and the node link in the execute state,
// where the result is loaded into the output register. A new word is taken
// only once the last has left the execute state, which must wait for the
// registered read of a node's link before a pointer update.
// The output register lets the next word be accepted while a result still
// waits. If the receiver holds off out_ready, the execute state of the next
// word waits until the output register is free.
// Reset sets all stacks empty, the free list empty and the fresh node count
// to zero. The node memories need no clearing.
// ----------------------------------------------------------------------------
module mergeable_linked_stack_pool_core #(
	parameter int POOL_SIZE  = 256,
	parameter int NUM_STACKS = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mlsp_pkg::OP_W-1:0]      operation,
	input  logic [mlsp_pkg::ID_W-1:0]      stack_id,
	input  logic [mlsp_pkg::ID_W-1:0]      other_stack_id,
	input  logic signed [mlsp_pkg::VAL_W-1:0] push_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [mlsp_pkg::VAL_W-1:0] pop_value,
	output logic [mlsp_pkg::STATUS_W-1:0]  status
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int PTR_W = $clog2(POOL_SIZE + 1);
	localparam int ID_SPAN = 1 << mlsp_pkg::ID_W;
	localparam int NSTK = (NUM_STACKS < ID_SPAN) ? NUM_STACKS : ID_SPAN;
	localparam int SID_W = $clog2(NSTK);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SIZE);
	localparam logic [mlsp_pkg::ID_W:0] NSTK_C = (mlsp_pkg::ID_W + 1)'(NSTK);

	mlsp_pkg::state_t  state_q, state_n;
	mlsp_pkg::op_t     op_q, op_in;
	logic [SID_W-1:0]  sid_q, oid_q, sid_in, oid_in;
	logic [mlsp_pkg::VAL_W-1:0] val_q;

	logic [PTR_W-1:0]  head_q [NSTK];
	logic [PTR_W-1:0]  tail_q [NSTK];
	logic [PTR_W-1:0]  head_n [NSTK];
	logic [PTR_W-1:0]  tail_n [NSTK];
	logic [PTR_W-1:0]  free_q, free_n;
	logic [PTR_W-1:0]  fresh_q, fresh_n;

	logic              out_valid_q;
	logic [mlsp_pkg::VAL_W-1:0] pop_value_q, res_value;
	mlsp_pkg::status_t status_q, res_status;

	logic              in_fire, exec_fire;
	logic [PTR_W-1:0]  rd_ptr;
	logic              rd_en;

	logic              lnk_we, val_we;
	logic [IDX_W-1:0]  lnk_waddr;
	logic [PTR_W-1:0]  lnk_wdata, lnk_rdata;
	logic [DATA_WIDTH-1:0] val_wdata, val_rdata;
	logic [mlsp_pkg::VAL_W-1:0] pop_word;

	logic              from_free, pool_full;
	logic [PTR_W-1:0]  new_node;

	logic [mlsp_pkg::ID_W:0] sid_ext, oid_ext, sid_wrap, oid_wrap;

	// Stack ids wrap modulo the number of stacks.
	always_comb begin
		sid_ext  = {1'b0, stack_id};
		oid_ext  = {1'b0, other_stack_id};
		sid_wrap = (sid_ext >= NSTK_C) ? sid_ext - NSTK_C : sid_ext;
		oid_wrap = (oid_ext >= NSTK_C) ? oid_ext - NSTK_C : oid_ext;
		sid_in   = sid_wrap[SID_W-1:0];
		oid_in   = oid_wrap[SID_W-1:0];
		op_in    = mlsp_pkg::op_t'(operation);
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mlsp_pkg::S_IDLE: begin
				if (in_valid) begin
					state_n = mlsp_pkg::S_EXEC;
				end
			end
			mlsp_pkg::S_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_n = mlsp_pkg::S_IDLE;
				end
			end
			default: state_n = mlsp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == mlsp_pkg::S_IDLE);
		exec_fire = (state_q == mlsp_pkg::S_EXEC) && (!out_valid_q || out_ready);
	end

	assign in_fire = in_valid && in_ready;

	always_comb begin
		rd_ptr = (op_in == mlsp_pkg::OP_POP) ? head_q[sid_in] : free_q;
		rd_en  = in_fire && (rd_ptr != NULL_PTR) &&
			((op_in == mlsp_pkg::OP_POP) || (op_in == mlsp_pkg::OP_PUSH));
	end

	generate
		if (DATA_WIDTH < mlsp_pkg::VAL_W) begin : g_narrow
			assign val_wdata = val_q[DATA_WIDTH-1:0];
			assign pop_word  = {{(mlsp_pkg::VAL_W - DATA_WIDTH){val_rdata[DATA_WIDTH-1]}},
				val_rdata};
		end else if (DATA_WIDTH == mlsp_pkg::VAL_W) begin : g_equal
			assign val_wdata = val_q;
			assign pop_word  = val_rdata;
		end else begin : g_wide
			assign val_wdata = {{(DATA_WIDTH - mlsp_pkg::VAL_W){val_q[mlsp_pkg::VAL_W-1]}},
				val_q};
			assign pop_word  = val_rdata[mlsp_pkg::VAL_W-1:0];
		end
	endgenerate

	always_comb begin
		from_free = (free_q != NULL_PTR);
		pool_full = !from_free && (fresh_q == NULL_PTR);
		new_node  = from_free ? free_q : fresh_q;
	end

	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		free_n     = free_q;
		fresh_n    = fresh_q;
		lnk_we     = 1'b0;
		val_we     = 1'b0;
		lnk_waddr  = new_node[IDX_W-1:0];
		lnk_wdata  = head_q[sid_q];
		res_value  = '0;
		res_status = mlsp_pkg::ST_OK;
		unique case (op_q)
			mlsp_pkg::OP_PUSH: begin
				if (pool_full) begin
					res_status = mlsp_pkg::ST_POOL_FULL;
				end else begin
					val_we    = 1'b1;
					lnk_we    = 1'b1;
					lnk_waddr = new_node[IDX_W-1:0];
					lnk_wdata = head_q[sid_q];
					if (head_q[sid_q] == NULL_PTR) begin
						tail_n[sid_q] = new_node;
					end
					head_n[sid_q] = new_node;
					if (from_free) begin
						free_n = lnk_rdata;
					end else begin
						fresh_n = fresh_q + PTR_W'(1);
					end
				end
			end
			mlsp_pkg::OP_POP: begin
				if (head_q[sid_q] == NULL_PTR) begin
					res_status = mlsp_pkg::ST_UNDERFLOW;
				end else begin
					res_value     = pop_word;
					head_n[sid_q] = lnk_rdata;
					if (lnk_rdata == NULL_PTR) begin
						tail_n[sid_q] = NULL_PTR;
					end
					lnk_we    = 1'b1;
					lnk_waddr = head_q[sid_q][IDX_W-1:0];
					lnk_wdata = free_q;
					free_n    = head_q[sid_q];
				end
			end
			mlsp_pkg::OP_MERGE: begin
				if (sid_q == oid_q) begin
					res_status = mlsp_pkg::ST_SELF_MERGE;
				end else if (head_q[oid_q] != NULL_PTR) begin
					if (head_q[sid_q] == NULL_PTR) begin
						head_n[sid_q] = head_q[oid_q];
					end else begin
						lnk_we    = 1'b1;
						lnk_waddr = tail_q[sid_q][IDX_W-1:0];
						lnk_wdata = head_q[oid_q];
					end
					tail_n[sid_q] = tail_q[oid_q];
					head_n[oid_q] = NULL_PTR;
					tail_n[oid_q] = NULL_PTR;
				end
			end
			mlsp_pkg::OP_NONE: begin
				res_status = mlsp_pkg::ST_OK;
			end
			default: res_status = mlsp_pkg::ST_OK;
		endcase
	end

	mlsp_ram #(
		.WIDTH(PTR_W),
		.DEPTH(POOL_SIZE)
	) u_link_ram (
		.clk   (clk),
		.we    (exec_fire && lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (rd_en),
		.raddr (rd_ptr[IDX_W-1:0]),
		.rdata (lnk_rdata)
	);

	mlsp_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(POOL_SIZE)
	) u_value_ram (
		.clk   (clk),
		.we    (exec_fire && val_we),
		.waddr (new_node[IDX_W-1:0]),
		.wdata (val_wdata),
		.re    (rd_en),
		.raddr (rd_ptr[IDX_W-1:0]),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlsp_pkg::S_IDLE;
			free_q  <= NULL_PTR;
			fresh_q <= '0;
			for (int i = 0; i < NSTK; i++) begin
				head_q[i] <= NULL_PTR;
				tail_q[i] <= NULL_PTR;
			end
		end else begin
			state_q <= state_n;
			if (exec_fire) begin
				free_q  <= free_n;
				fresh_q <= fresh_n;
				head_q  <= head_n;
				tail_q  <= tail_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op_in;
			sid_q <= sid_in;
			oid_q <= oid_in;
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			pop_value_q <= res_value;
			status_q    <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mlsp_pkg::S_EXEC))
		else $error("result word appeared without an execute cycle");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NULL_PTR)
		else $error("fresh node count ran past the pool size");

	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == mlsp_pkg::ST_UNDERFLOW)) |-> (pop_value_q == '0))
		else $error("underflow result carries a nonzero value");

	generate
		for (genvar g = 0; g < NSTK; g++) begin : g_chk
			a_head_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
				(head_q[g] == NULL_PTR) == (tail_q[g] == NULL_PTR))
				else $error("stack head and tail disagree on emptiness");
		end
	endgenerate

endmodule
